// ===== rtl/pulse_blink_output_controller_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pulse/blink output controller.
// ----------------------------------------------------------------------------
`ifndef PULSE_BLINK_OUTPUT_CONTROLLER_TOP_ASSERT_SVH
`define PULSE_BLINK_OUTPUT_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PBOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pboc assertion failed");

// next-cycle implication, checked out of reset
`define PBOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pboc assertion failed");

`endif

// ===== rtl/pboc_pkg.sv =====
// ----------------------------------------------------------------------------
// pboc_pkg
// Types and constants for the pulse/blink output controller.
// ----------------------------------------------------------------------------
package pboc_pkg;

    localparam int LEN_W    = 32;
    localparam int COUNT_W  = 8;
    localparam int CYCLES_W = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic ACTIVE_LEVEL_RST = 1'b1;
    localparam logic [PADDR_W-3:0] REG_ACTIVE_LEVEL = '0;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_START_PULSE = 2'd1,
        OP_START_BLINK = 2'd2,
        OP_STOP        = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_BLINK = 2'd2
    } t_mode;

endpackage

// ===== rtl/pulse_blink_output_controller_top.sv =====
// ----------------------------------------------------------------------------
// pulse_blink_output_controller_top
// Single-pin controller: idle, one-shot pulse or blinking, driven by commands.
// ----------------------------------------------------------------------------
// Takes one transaction per clock: each command (tick, start pulse, start
// blink, stop) updates the mode state and writes one result into the output
// register in the same cycle, so a result is available in the cycle after
// acceptance. The input is ready whenever the output register is empty or
// being drained, giving one transaction per cycle under no back-pressure.
// The active level is written through the APB port at byte address 0.
`include "pulse_blink_output_controller_top_assert.svh"

module pulse_blink_output_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_operation,
    input  logic [pboc_pkg::LEN_W-1:0]        i_pulse_length,
    input  logic [pboc_pkg::LEN_W-1:0]        i_on_length,
    input  logic [pboc_pkg::LEN_W-1:0]        i_off_length,
    input  logic signed [pboc_pkg::COUNT_W-1:0] i_cycle_count,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_pin_level,
    output logic                              o_busy_res,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pboc_pkg::PADDR_W-1:0]      paddr,
    input  logic [pboc_pkg::PDATA_W-1:0]      pwdata,
    output logic [pboc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam logic [pboc_pkg::LEN_W-1:0] LEN_MAX = '1;

    pboc_pkg::t_mode              r_mode, n_mode;
    logic                         r_lit, n_lit;
    logic [pboc_pkg::LEN_W-1:0]   r_elapsed, n_elapsed;
    logic [pboc_pkg::LEN_W-1:0]   r_pulse_len, n_pulse_len;
    logic [pboc_pkg::LEN_W-1:0]   r_on_len, n_on_len;
    logic [pboc_pkg::LEN_W-1:0]   r_off_len, n_off_len;
    logic [pboc_pkg::CYCLES_W-1:0] r_cycles_left, n_cycles_left;
    logic                         r_limited, n_limited;
    logic                         r_active_level;
    logic                         r_out_valid;
    logic                         r_pin_level;
    logic                         r_busy;

    logic                         in_accept;
    logic                         cfg_write;
    logic [pboc_pkg::LEN_W-1:0]   elapsed_inc;
    logic [pboc_pkg::CYCLES_W-1:0] cycles_dec;
    pboc_pkg::t_op                op;

    assign op          = pboc_pkg::t_op'(i_operation);
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign elapsed_inc = (r_elapsed == LEN_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign cycles_dec  = (r_cycles_left != '0) ? r_cycles_left - 1'b1 : r_cycles_left;

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[pboc_pkg::PADDR_W-1:2] == pboc_pkg::REG_ACTIVE_LEVEL) ?
                       {{(pboc_pkg::PDATA_W-1){1'b0}}, r_active_level} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= pboc_pkg::ACTIVE_LEVEL_RST;
        end else if (cfg_write &&
                     paddr[pboc_pkg::PADDR_W-1:2] == pboc_pkg::REG_ACTIVE_LEVEL) begin
            r_active_level <= pwdata[0];
        end
    end

    // next state
    always_comb begin
        n_mode        = r_mode;
        n_lit         = r_lit;
        n_elapsed     = r_elapsed;
        n_pulse_len   = r_pulse_len;
        n_on_len      = r_on_len;
        n_off_len     = r_off_len;
        n_cycles_left = r_cycles_left;
        n_limited     = r_limited;
        if (in_accept) begin
            unique case (op)
                pboc_pkg::OP_TICK: begin
                    n_elapsed = elapsed_inc;
                    unique case (r_mode)
                        pboc_pkg::MODE_PULSE: begin
                            if (elapsed_inc >= r_pulse_len) begin
                                n_mode        = pboc_pkg::MODE_IDLE;
                                n_lit         = 1'b0;
                                n_elapsed     = '0;
                                n_cycles_left = '0;
                                n_limited     = 1'b0;
                            end
                        end
                        pboc_pkg::MODE_BLINK: begin
                            if (r_lit) begin
                                if (elapsed_inc >= r_on_len) begin
                                    n_lit     = 1'b0;
                                    n_elapsed = '0;
                                end
                            end else if (elapsed_inc >= r_off_len) begin
                                n_lit     = 1'b1;
                                n_elapsed = '0;
                                if (r_limited) begin
                                    n_cycles_left = cycles_dec;
                                    if (cycles_dec == '0) begin
                                        n_mode    = pboc_pkg::MODE_IDLE;
                                        n_lit     = 1'b0;
                                        n_limited = 1'b0;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                pboc_pkg::OP_START_PULSE: begin
                    if (r_mode != pboc_pkg::MODE_PULSE) begin
                        n_mode        = pboc_pkg::MODE_PULSE;
                        n_lit         = 1'b1;
                        n_elapsed     = '0;
                        n_cycles_left = '0;
                        n_limited     = 1'b0;
                        n_pulse_len   = i_pulse_length;
                    end
                end
                pboc_pkg::OP_START_BLINK: begin
                    if (r_mode != pboc_pkg::MODE_BLINK) begin
                        n_mode        = pboc_pkg::MODE_BLINK;
                        n_lit         = 1'b1;
                        n_elapsed     = '0;
                        n_on_len      = i_on_length;
                        n_off_len     = i_off_length;
                        if (i_cycle_count > 0) begin
                            n_limited     = 1'b1;
                            n_cycles_left = i_cycle_count[pboc_pkg::CYCLES_W-1:0];
                        end else begin
                            n_limited     = 1'b0;
                            n_cycles_left = '0;
                        end
                    end
                end
                pboc_pkg::OP_STOP: begin
                    n_mode        = pboc_pkg::MODE_IDLE;
                    n_lit         = 1'b0;
                    n_elapsed     = '0;
                    n_cycles_left = '0;
                    n_limited     = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= pboc_pkg::MODE_IDLE;
            r_lit         <= 1'b0;
            r_elapsed     <= '0;
            r_pulse_len   <= '0;
            r_on_len      <= '0;
            r_off_len     <= '0;
            r_cycles_left <= '0;
            r_limited     <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_lit         <= n_lit;
            r_elapsed     <= n_elapsed;
            r_pulse_len   <= n_pulse_len;
            r_on_len      <= n_on_len;
            r_off_len     <= n_off_len;
            r_cycles_left <= n_cycles_left;
            r_limited     <= n_limited;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pin_level <= n_lit ? r_active_level : !r_active_level;
            r_busy      <= (n_mode != pboc_pkg::MODE_IDLE);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pin_level = r_pin_level;
    assign o_busy_res  = r_busy;

    // assertions
    `PBOC_ASSERT_NOW(a_idle_is_dark, i_clk, i_rst_n,
        r_mode == pboc_pkg::MODE_IDLE, !r_lit)
    `PBOC_ASSERT_NOW(a_limited_in_blink, i_clk, i_rst_n,
        r_limited, r_mode == pboc_pkg::MODE_BLINK && r_cycles_left != '0)
    `PBOC_ASSERT_NEXT(a_stop_clears, i_clk, i_rst_n,
        in_accept && op == pboc_pkg::OP_STOP,
        r_mode == pboc_pkg::MODE_IDLE && r_elapsed == '0 && !r_limited)
    `PBOC_ASSERT_NEXT(a_result_matches_state, i_clk, i_rst_n,
        in_accept, o_out_valid && o_busy_res == (r_mode != pboc_pkg::MODE_IDLE))

endmodule
